/* src/tcbr_pkg.sv */
// Shared types and constants for the torus corner-buffer router step.
package tcbr_pkg;

  localparam int DEST_W     = 6;
  localparam int PAYLOAD_W  = 32;
  localparam int RANK_W     = 6;
  localparam int THR_W      = 4;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [RANK_W-1:0] RANK_RESET = 6'd0;
  localparam logic [THR_W-1:0]  THR_RESET  = 4'd4;
  localparam logic [1:0]        PHASE_LAST = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_RANK,
    CFG_FREE_SLOT_THRESHOLD
  } cfg_reg_t;

  typedef struct packed {
    logic [DEST_W-1:0]    dest;
    logic [PAYLOAD_W-1:0] payload;
  } flit_t;

  typedef struct packed {
    logic                 south_valid;
    logic [DEST_W-1:0]    south_dest;
    logic [PAYLOAD_W-1:0] south_payload;
    logic                 west_valid;
    logic [DEST_W-1:0]    west_dest;
    logic                 west_marked;
    logic [PAYLOAD_W-1:0] west_payload;
    logic                 inject_valid;
    logic [DEST_W-1:0]    inject_dest;
    logic [PAYLOAD_W-1:0] inject_payload;
    logic                 east_request;
  } in_beat_t;

  typedef struct packed {
    logic                 north_valid;
    logic [DEST_W-1:0]    north_dest;
    logic [PAYLOAD_W-1:0] north_payload;
    logic                 east_valid;
    logic [DEST_W-1:0]    east_dest;
    logic                 east_mark;
    logic [PAYLOAD_W-1:0] east_payload;
    logic                 core_valid;
    logic [PAYLOAD_W-1:0] core_payload;
    logic                 west_request;
    logic                 inject_accepted;
  } out_beat_t;

endpackage

/* src/torus_corner_buffer_router_step_top.sv */
// Top level of the torus corner-buffer router step.
// One beat in is one network cycle of the router; one result beat comes out for each.
// A new beat is taken every clock cycle while results are taken. A taken beat is held in
// the input register; when it advances, the router update is applied to the node state and
// the result register is loaded. The rate is set by that update of the injection queue,
// corner queue, core-in slot and column timeouts, which every beat reads and writes. There
// is no clearing pass after reset; the node is ready at once.
// The output stage stalls when the result is not taken, and the input register then
// holds one more beat before in_ready drops.
module torus_corner_buffer_router_step_top
  import tcbr_pkg::*;
#(
  parameter int TORUS_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(TORUS_WIDTH);
  localparam int CNT_W = $clog2(TORUS_WIDTH + 1);
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int RANKS = 1 << DEST_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TORUS_WIDTH);
  localparam logic [COL_W-1:0] LAST_PTR = COL_W'(TORUS_WIDTH - 1);

  logic [COL_W-1:0] col_lut [RANKS];
  logic             row_even_lut [RANKS];

  for (genvar g = 0; g < RANKS; g++) begin : g_lut
    assign col_lut[g]      = COL_W'(g % TORUS_WIDTH);
    assign row_even_lut[g] = ((g / TORUS_WIDTH) % 2) == 0;
  end

  function automatic logic [COL_W-1:0] ptr_inc(input logic [COL_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  logic [RANK_W-1:0] rank_r;
  logic [THR_W-1:0]  thr_r;
  logic              corner_on_r;
  logic [1:0]        phase_r;
  logic              sent_east_r;
  logic [CNT_W-1:0]  to_r [TORUS_WIDTH];

  flit_t             inj_mem_r [TORUS_WIDTH];
  logic [COL_W-1:0]  inj_head_r, inj_tail_r;
  logic [CNT_W-1:0]  inj_cnt_r;
  flit_t             cr_mem_r [TORUS_WIDTH];
  logic [COL_W-1:0]  cr_head_r, cr_tail_r;
  logic [CNT_W-1:0]  cr_cnt_r;
  logic              slot_v_r;
  flit_t             slot_r;

  logic              s1_v_r;
  in_beat_t          s1_r;
  logic              out_v_r;
  out_beat_t         out_r;

  logic              advance;

  logic              inj_pop, inj_push, bypass, accepted;
  logic              cs_v, cs_used;
  flit_t             cs_f;
  logic [COL_W-1:0]  my_col, w_col, cs_col;
  logic              n_v, c_v, e_v, e_m, south_to_core, west_to_corner, sig_west;
  flit_t             n_f, e_f, w_f, cr_head_f;
  logic [PAYLOAD_W-1:0] c_pay;
  logic              cr_pop, cr_push, w_fail;
  flit_t             cr_push_f;
  logic [CNT_W-1:0]  cr_cnt_mid, free_slots;
  logic              sent_east_nxt, corner_on_nxt;
  logic [1:0]        phase_nxt;
  logic [CNT_W-1:0]  to_mid [TORUS_WIDTH];
  logic [CNT_W-1:0]  to_nxt [TORUS_WIDTH];
  out_beat_t         out_nxt;

  assign advance   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    inj_pop  = !slot_v_r && (inj_cnt_r != '0);
    accepted = s1_r.inject_valid && ((inj_cnt_r != FULL_CNT) || inj_pop);
    bypass   = !slot_v_r && (inj_cnt_r == '0) && accepted;
    inj_push = accepted && !bypass;
    cs_v     = slot_v_r || inj_pop || bypass;
    if (slot_v_r) begin
      cs_f = slot_r;
    end else if (inj_pop) begin
      cs_f = inj_mem_r[inj_head_r];
    end else begin
      cs_f.dest    = s1_r.inject_dest;
      cs_f.payload = s1_r.inject_payload;
    end

    my_col = col_lut[rank_r];

    n_v           = 1'b0;
    c_v           = 1'b0;
    south_to_core = 1'b0;
    n_f           = '0;
    c_pay         = '0;
    if (s1_r.south_valid) begin
      if (s1_r.south_dest == rank_r) begin
        c_v           = 1'b1;
        south_to_core = 1'b1;
        c_pay         = s1_r.south_payload;
      end else begin
        n_v          = 1'b1;
        n_f.dest     = s1_r.south_dest;
        n_f.payload  = s1_r.south_payload;
      end
    end

    cr_head_f  = cr_mem_r[cr_head_r];
    free_slots = FULL_CNT - cr_cnt_r;
    cr_pop     = 1'b0;
    if ((cr_cnt_r != '0) &&
        (corner_on_r || (CMP_W'(free_slots) < CMP_W'(thr_r)) || (phase_r == 2'd0))) begin
      if ((cr_head_f.dest == rank_r) && !south_to_core) begin
        cr_pop = 1'b1;
        c_v    = 1'b1;
        c_pay  = cr_head_f.payload;
      end else if (!n_v) begin
        cr_pop = 1'b1;
        n_v    = 1'b1;
        n_f    = cr_head_f;
      end
    end
    cr_cnt_mid = cr_pop ? cr_cnt_r - 1'b1 : cr_cnt_r;

    if (phase_r == PHASE_LAST) begin
      phase_nxt     = 2'd0;
      corner_on_nxt = !corner_on_r;
    end else begin
      phase_nxt     = phase_r + 2'd1;
      corner_on_nxt = corner_on_r;
    end

    w_f.dest       = s1_r.west_dest;
    w_f.payload    = s1_r.west_payload;
    w_col          = col_lut[s1_r.west_dest];
    e_v            = 1'b0;
    e_m            = 1'b0;
    e_f            = '0;
    cr_push        = 1'b0;
    cr_push_f      = w_f;
    west_to_corner = 1'b0;
    w_fail         = 1'b0;
    if (s1_r.west_valid) begin
      if ((w_col == my_col) && (to_r[my_col] == '0)) begin
        if (cr_cnt_mid == FULL_CNT) begin
          e_v    = 1'b1;
          e_m    = 1'b1;
          e_f    = w_f;
          w_fail = 1'b1;
        end else begin
          cr_push        = 1'b1;
          west_to_corner = 1'b1;
        end
      end else begin
        e_v = 1'b1;
        e_m = s1_r.west_marked;
        e_f = w_f;
      end
    end

    for (int i = 0; i < TORUS_WIDTH; i++) begin
      to_mid[i] = to_r[i];
      if (s1_r.west_valid && s1_r.west_marked && (w_col != my_col) &&
          (w_col == COL_W'(i))) begin
        to_mid[i] = FULL_CNT;
      end
      if (w_fail && (my_col == COL_W'(i))) begin
        to_mid[i] = FULL_CNT;
      end
    end

    cs_col        = col_lut[cs_f.dest];
    cs_used       = 1'b0;
    sig_west      = 1'b0;
    sent_east_nxt = sent_east_r;
    if (cs_v) begin
      if (cs_col == my_col) begin
        if (!west_to_corner && (to_mid[my_col] == '0) && (cr_cnt_mid != FULL_CNT)) begin
          cr_push   = 1'b1;
          cr_push_f = cs_f;
          cs_used   = 1'b1;
        end else if (west_to_corner && (to_mid[my_col] == '0)) begin
          sig_west = 1'b1;
        end
      end else begin
        if (!e_v && (to_mid[cs_col] == '0) && (!s1_r.east_request || !sent_east_r)) begin
          e_v           = 1'b1;
          e_m           = 1'b0;
          e_f           = cs_f;
          cs_used       = 1'b1;
          sent_east_nxt = 1'b1;
        end else if (!e_v) begin
          sent_east_nxt = 1'b0;
        end else if (s1_r.east_request || (to_mid[cs_col] == '0)) begin
          sig_west = 1'b1;
        end
      end
    end else if (!e_v) begin
      sent_east_nxt = 1'b0;
    end else if (s1_r.east_request) begin
      sig_west = 1'b1;
    end

    for (int i = 0; i < TORUS_WIDTH; i++) begin
      to_nxt[i] = (to_mid[i] != '0) ? to_mid[i] - 1'b1 : '0;
    end

    out_nxt                 = '0;
    out_nxt.north_valid     = n_v;
    out_nxt.north_dest      = n_f.dest;
    out_nxt.north_payload   = n_f.payload;
    out_nxt.east_valid      = e_v;
    out_nxt.east_dest       = e_f.dest;
    out_nxt.east_mark       = e_v && e_m;
    out_nxt.east_payload    = e_f.payload;
    out_nxt.core_valid      = c_v;
    out_nxt.core_payload    = c_pay;
    out_nxt.west_request    = sig_west;
    out_nxt.inject_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      rank_r      <= RANK_RESET;
      thr_r       <= THR_RESET;
      corner_on_r <= row_even_lut[RANK_RESET];
      phase_r     <= 2'd0;
      sent_east_r <= 1'b0;
      slot_v_r    <= 1'b0;
      inj_head_r  <= '0;
      inj_tail_r  <= '0;
      inj_cnt_r   <= '0;
      cr_head_r   <= '0;
      cr_tail_r   <= '0;
      cr_cnt_r    <= '0;
      for (int i = 0; i < TORUS_WIDTH; i++) begin
        to_r[i] <= '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end

      if (advance) begin
        phase_r     <= phase_nxt;
        corner_on_r <= corner_on_nxt;
        sent_east_r <= sent_east_nxt;
        slot_v_r    <= cs_v && !cs_used;
        if (inj_pop) begin
          inj_head_r <= ptr_inc(inj_head_r);
        end
        if (inj_push) begin
          inj_tail_r <= ptr_inc(inj_tail_r);
        end
        inj_cnt_r <= inj_cnt_r + CNT_W'(inj_push) - CNT_W'(inj_pop);
        if (cr_pop) begin
          cr_head_r <= ptr_inc(cr_head_r);
        end
        if (cr_push) begin
          cr_tail_r <= ptr_inc(cr_tail_r);
        end
        cr_cnt_r <= cr_cnt_mid + CNT_W'(cr_push);
        for (int i = 0; i < TORUS_WIDTH; i++) begin
          to_r[i] <= to_nxt[i];
        end
      end

      if (cfg_we) begin
        if (cfg_index == CFG_NODE_RANK) begin
          rank_r      <= cfg_data[RANK_W-1:0];
          corner_on_r <= row_even_lut[cfg_data[RANK_W-1:0]];
        end else if (cfg_index == CFG_FREE_SLOT_THRESHOLD) begin
          thr_r <= cfg_data[THR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r  <= out_nxt;
      slot_r <= cs_f;
      if (inj_push) begin
        inj_mem_r[inj_tail_r].dest    <= s1_r.inject_dest;
        inj_mem_r[inj_tail_r].payload <= s1_r.inject_payload;
      end
      if (cr_push) begin
        cr_mem_r[cr_tail_r] <= cr_push_f;
      end
    end
  end

endmodule

/* src/tcbr_checker.sv */
// Port-level checker for the torus corner-buffer router step, bound to the top level.
module tcbr_checker
  import tcbr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("Stalled result beat changed or dropped.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the result register was empty.");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("Result beat appeared without a beat taken two cycles earlier.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Result beat present right after reset.");

endmodule

bind torus_corner_buffer_router_step_top tcbr_checker u_tcbr_checker (.*);
